// ===== src/mde_pkg.sv =====
// Shared constants, types and codes for the Mandelbrot dwell engine.
`default_nettype none

package mde_pkg;

	// Fixed-point format of the iterate and width of the iteration counter.
	localparam int FRAC_BITS   = 28;
	localparam int COUNT_WIDTH = 18;

	// Widths fixed by the interface.
	localparam int C_WIDTH         = 32;
	localparam int C_FRAC          = 28;
	localparam int Z_WIDTH         = 64;
	localparam int MAG_WIDTH       = 63;
	localparam int DWELL_WIDTH     = 18;
	localparam int MAXIT_WIDTH     = 18;
	localparam int LIMIT_WIDTH     = 26;
	localparam int CFG_DATA_WIDTH  = 26;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [MAXIT_WIDTH-1:0] MAXIT_RESET = 18'd65536;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 26'd60000000;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_MAX_ITER  = 1'b0,
		CFG_ESC_LIMIT = 1'b1
	} cfg_reg_t;

	// Aligned point c, both parts signed with FRAC_BITS fraction bits.
	typedef struct packed {
		logic [Z_WIDTH-1:0] cx;
		logic [Z_WIDTH-1:0] cy;
	} point_t;

	typedef enum logic [1:0] {
		MUL_XY,
		MUL_XX,
		MUL_YY
	} mul_op_t;

	typedef struct packed {
		logic                 valid;
		mul_op_t              op;
		logic [MAG_WIDTH-1:0] a;
		logic [MAG_WIDTH-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 valid;
		mul_op_t              op;
		logic [MAG_WIDTH-1:0] res;
		logic                 ovf;
	} mul_rsp_t;

	typedef enum logic [2:0] {
		IT_IDLE,
		IT_MAG,
		IT_MUL_XY,
		IT_MUL_XX,
		IT_MUL_YY,
		IT_WAIT,
		IT_SUM,
		IT_DECIDE
	} iter_state_t;

endpackage

`default_nettype wire

// ===== src/mde_front.sv =====
// Front end: takes points, aligns c to the iterate format and queues them.
`default_nettype none

module mde_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mde_pkg::C_WIDTH-1:0] point_real,
	input  wire logic [mde_pkg::C_WIDTH-1:0] point_imag,
	output logic                             busy,
	output logic                             pt_valid,
	input  wire logic                        pt_take,
	output mde_pkg::point_t                  pt
);

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int ALIGN_L = (mde_pkg::FRAC_BITS >= mde_pkg::C_FRAC) ?
		mde_pkg::FRAC_BITS - mde_pkg::C_FRAC : 0;
	localparam int ALIGN_R = (mde_pkg::FRAC_BITS >= mde_pkg::C_FRAC) ?
		0 : mde_pkg::C_FRAC - mde_pkg::FRAC_BITS;

	// A right shift of the signed value floors, as the format change requires.
	function automatic logic [mde_pkg::Z_WIDTH-1:0] align_c(
		input logic [mde_pkg::C_WIDTH-1:0] raw
	);
		logic signed [mde_pkg::Z_WIDTH-1:0] v;
		v = mde_pkg::Z_WIDTH'(signed'(raw));
		v = v <<< ALIGN_L;
		v = v >>> ALIGN_R;
		return v;
	endfunction

	mde_pkg::point_t     q_mem [QDEPTH];
	logic [QPTR_W-1:0]   q_wr_q;
	logic [QPTR_W-1:0]   q_rd_q;
	logic [QCNT_W-1:0]   q_cnt_q;
	logic                accept;
	mde_pkg::point_t     in_pt;

	assign busy     = (q_cnt_q == QCNT_W'(QDEPTH));
	assign accept   = start & ~busy;
	assign pt_valid = (q_cnt_q != '0);
	assign pt       = q_mem[q_rd_q];

	always_comb begin
		in_pt.cx = align_c(point_real);
		in_pt.cy = align_c(point_imag);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[q_wr_q] <= in_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (accept) begin
				q_wr_q <= q_wr_q + QPTR_W'(1);
			end
			if (pt_take) begin
				q_rd_q <= q_rd_q + QPTR_W'(1);
			end
			priority if (accept && !pt_take) begin
				q_cnt_q <= q_cnt_q + QCNT_W'(1);
			end else if (pt_take && !accept) begin
				q_cnt_q <= q_cnt_q - QCNT_W'(1);
			end
		end
	end

	// The back end only ever takes a point that is actually queued.
	a_take_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pt_take |-> pt_valid)
		else $error("point taken from an empty queue");

endmodule

`default_nettype wire

// ===== src/mde_mul.sv =====
// Shared four-stage 63x63-bit magnitude multiplier with scaling and saturation.
`default_nettype none

module mde_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mde_pkg::mul_req_t req,
	output mde_pkg::mul_rsp_t      rsp
);

	localparam int MW    = mde_pkg::MAG_WIDTH;
	localparam int SH_SQ = mde_pkg::FRAC_BITS;
	localparam int SH_XY = mde_pkg::FRAC_BITS - 1;

	logic [63:0]        p00_s1;
	logic [62:0]        p01_s1;
	logic [62:0]        p10_s1;
	logic [61:0]        p11_s1;
	logic [33:0]        mid_s2;
	logic [63:0]        hip_s2;
	logic [31:0]        lo_s2;
	logic [63:0]        hi_s3;
	logic [63:0]        lo_s3;
	logic [MW-1:0]      res_s4;
	logic               ovf_s4;
	logic               v_s1, v_s2, v_s3, v_s4;
	mde_pkg::mul_op_t   op_s1, op_s2, op_s3, op_s4;

	logic [127:0]       full;
	logic [127:0]       shift_sq;
	logic [127:0]       shift_xy;
	logic               ovf_sq;
	logic               ovf_xy;
	logic [MW-1:0]      res_sel;
	logic               ovf_sel;

	// Final stage: the exact product is scaled by a fixed shift that depends on
	// the operation, and anything that does not fit in 63 bits saturates.
	always_comb begin
		full     = {hi_s3, lo_s3};
		shift_sq = full >> SH_SQ;
		shift_xy = full >> SH_XY;
		ovf_sq   = |(full >> (SH_SQ + MW));
		ovf_xy   = |(full >> (SH_XY + MW));
		if (op_s3 == mde_pkg::MUL_XY) begin
			ovf_sel = ovf_xy;
			res_sel = ovf_xy ? '1 : shift_xy[MW-1:0];
		end else begin
			ovf_sel = ovf_sq;
			res_sel = ovf_sq ? '1 : shift_sq[MW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		p00_s1 <= req.a[31:0]  * req.b[31:0];
		p01_s1 <= req.a[31:0]  * req.b[MW-1:32];
		p10_s1 <= req.a[MW-1:32] * req.b[31:0];
		p11_s1 <= req.a[MW-1:32] * req.b[MW-1:32];
		op_s1  <= req.op;

		mid_s2 <= {2'b00, p00_s1[63:32]} + {2'b00, p01_s1[31:0]} + {2'b00, p10_s1[31:0]};
		hip_s2 <= {2'b00, p11_s1} + {33'd0, p01_s1[62:32]} + {33'd0, p10_s1[62:32]};
		lo_s2  <= p00_s1[31:0];
		op_s2  <= op_s1;

		hi_s3  <= hip_s2 + {62'd0, mid_s2[33:32]};
		lo_s3  <= {mid_s2[31:0], lo_s2};
		op_s3  <= op_s2;

		res_s4 <= res_sel;
		ovf_s4 <= ovf_sel;
		op_s4  <= op_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign rsp.valid = v_s4;
	assign rsp.op    = op_s4;
	assign rsp.res   = res_s4;
	assign rsp.ovf   = ovf_s4;

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> ##4 rsp.valid)
		else $error("multiplier response did not arrive four cycles after issue");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ovf |-> (rsp.res == '1))
		else $error("overflowed product is not saturated");

endmodule

`default_nettype wire

// ===== src/mde_iter.sv =====
// Back end: runs the escape-time iteration for one point at a time.
`default_nettype none

module mde_iter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pt_valid,
	output logic                                 pt_take,
	input  wire mde_pkg::point_t                 pt,
	input  wire logic [mde_pkg::MAXIT_WIDTH-1:0] max_iter,
	input  wire logic [mde_pkg::LIMIT_WIDTH-1:0] esc_limit,
	output mde_pkg::mul_req_t                    mul_req,
	input  wire mde_pkg::mul_rsp_t               mul_rsp,
	output logic                                 done,
	output logic [mde_pkg::DWELL_WIDTH-1:0]      dwell,
	output logic                                 inside_res
);

	localparam int ZW = mde_pkg::Z_WIDTH;
	localparam int MW = mde_pkg::MAG_WIDTH;
	localparam int CW = mde_pkg::COUNT_WIDTH;
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << CW) - 64'd1);
	localparam logic [ZW-1:0] Z_MAX = {1'b0, {(ZW-1){1'b1}}};
	localparam logic [ZW-1:0] Z_MIN = {1'b1, {(ZW-2){1'b0}}, 1'b1};

	function automatic logic [MW-1:0] mag(input logic [ZW-1:0] v);
		logic [ZW-1:0] n;
		n = v[ZW-1] ? (~v + ZW'(1)) : v;
		return n[MW-1:0];
	endfunction

	// Clamp a 65-bit sum to the symmetric range of the iterate.
	function automatic logic [ZW-1:0] sat_z(input logic [ZW:0] s);
		logic [ZW-1:0] r;
		priority if (!s[ZW] && s[ZW-1]) begin
			r = Z_MAX;
		end else if (s[ZW] && (!s[ZW-1] || (s[ZW-2:0] == '0))) begin
			r = Z_MIN;
		end else begin
			r = s[ZW-1:0];
		end
		return r;
	endfunction

	mde_pkg::iter_state_t state_q, state_d;

	logic [ZW-1:0] cx_q, cy_q;
	logic [ZW-1:0] zr_q, zi_q;
	logic [MW-1:0] mzr_q, mzi_q;
	logic          xy_neg_q;
	logic [MW-1:0] x2_q, y2_q;
	logic          ovfx_q, ovfy_q;
	logic          esc_q;
	logic [ZW-1:0] diff_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          inside_q;

	logic [31:0]   max_ext;
	logic [CW-1:0] cap;
	logic          finish;
	logic [ZW:0]   zi_sum;
	logic [ZW:0]   zr_sum;
	logic [ZW-1:0] sq_sum;

	always_comb begin
		max_ext = 32'(max_iter);
		cap     = (max_ext < CNT_MAX) ? max_ext[CW-1:0] : CNT_MAX[CW-1:0];
		// Escape wins over the cap when both hold in the same check.
		finish  = esc_q || (cnt_q >= cap);
		zi_sum  = xy_neg_q ? ({cy_q[ZW-1], cy_q} - {2'b00, mul_rsp.res})
		                   : ({cy_q[ZW-1], cy_q} + {2'b00, mul_rsp.res});
		zr_sum  = {diff_q[ZW-1], diff_q} + {cx_q[ZW-1], cx_q};
		sq_sum  = {1'b0, x2_q} + {1'b0, y2_q};
	end

	always_comb begin
		state_d       = state_q;
		pt_take       = 1'b0;
		mul_req.valid = 1'b0;
		mul_req.op    = mde_pkg::MUL_XY;
		mul_req.a     = mzr_q;
		mul_req.b     = mzi_q;
		unique case (state_q)
			mde_pkg::IT_IDLE: begin
				if (pt_valid) begin
					pt_take = 1'b1;
					state_d = mde_pkg::IT_MAG;
				end
			end
			mde_pkg::IT_MAG: begin
				state_d = mde_pkg::IT_MUL_XY;
			end
			mde_pkg::IT_MUL_XY: begin
				mul_req.valid = 1'b1;
				state_d       = mde_pkg::IT_MUL_XX;
			end
			mde_pkg::IT_MUL_XX: begin
				mul_req.valid = 1'b1;
				mul_req.op    = mde_pkg::MUL_XX;
				mul_req.b     = mzr_q;
				state_d       = mde_pkg::IT_MUL_YY;
			end
			mde_pkg::IT_MUL_YY: begin
				mul_req.valid = 1'b1;
				mul_req.op    = mde_pkg::MUL_YY;
				mul_req.a     = mzi_q;
				state_d       = mde_pkg::IT_WAIT;
			end
			mde_pkg::IT_WAIT: begin
				if (mul_rsp.valid && (mul_rsp.op == mde_pkg::MUL_YY)) begin
					state_d = mde_pkg::IT_SUM;
				end
			end
			mde_pkg::IT_SUM: begin
				state_d = mde_pkg::IT_DECIDE;
			end
			mde_pkg::IT_DECIDE: begin
				state_d = finish ? mde_pkg::IT_IDLE : mde_pkg::IT_MAG;
			end
			default: begin
				state_d = mde_pkg::IT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mde_pkg::IT_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == mde_pkg::IT_DECIDE) && finish;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mde_pkg::IT_IDLE: begin
				if (pt_valid) begin
					cx_q   <= pt.cx;
					cy_q   <= pt.cy;
					zr_q   <= '0;
					zi_q   <= '0;
					cnt_q  <= '0;
				end
			end
			mde_pkg::IT_MAG: begin
				mzr_q    <= mag(zr_q);
				mzi_q    <= mag(zi_q);
				xy_neg_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
			end
			mde_pkg::IT_SUM: begin
				esc_q  <= ovfx_q | ovfy_q |
				          ((sq_sum >> mde_pkg::FRAC_BITS) >= ZW'(esc_limit));
				diff_q <= {1'b0, x2_q} - {1'b0, y2_q};
			end
			mde_pkg::IT_DECIDE: begin
				inside_q <= ~esc_q;
				if (!finish) begin
					zr_q  <= sat_z(zr_sum);
					cnt_q <= cnt_q + CW'(1);
				end
			end
			default: begin
			end
		endcase

		if (mul_rsp.valid) begin
			unique case (mul_rsp.op)
				mde_pkg::MUL_XY: begin
					zi_q <= sat_z(zi_sum);
				end
				mde_pkg::MUL_XX: begin
					x2_q   <= mul_rsp.res;
					ovfx_q <= mul_rsp.ovf;
				end
				mde_pkg::MUL_YY: begin
					y2_q   <= mul_rsp.res;
					ovfy_q <= mul_rsp.ovf;
				end
				default: begin
				end
			endcase
		end
	end

	assign done       = done_q;
	assign dwell      = mde_pkg::DWELL_WIDTH'(cnt_q);
	assign inside_res = inside_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_rsp_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.valid |-> (state_q == mde_pkg::IT_WAIT))
		else $error("multiplier response outside the wait state");

	a_take_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pt_take |=> (state_q == mde_pkg::IT_MAG) && (cnt_q == '0))
		else $error("new point did not start from a cleared count");

endmodule

`default_nettype wire

// ===== src/mandelbrot_dwell_engine_top.sv =====
// Top level of the Mandelbrot dwell engine: configuration registers and wiring.
`default_nettype none

// The engine takes a point c (signed Q4.28 real and imaginary parts) whenever
// start is high and busy is low, iterates z = z*z + c from z = 0 and returns
// the number of steps taken before |z|^2 reached the escape limit or the count
// reached max_iterations, with inside_res set when the cap was hit without an
// escape. Each result appears on dwell and inside_res for exactly one cycle,
// marked by done; there is no way to hold it off, so the receiver must take the
// transfer in that cycle. Results come back in the order the points went in.
// A two-entry queue sits between the input and the iteration core, so up to two
// further points can be handed over while one is being worked on; busy rises
// only when that queue is full. In each iteration the core forms the magnitudes
// of z, issues the three products (x*y, x*x, y*y) one after another into a
// single shared four-stage multiplier built from 32-bit partial products, then
// forms the escape sum and updates z. The iterate is held as a signed 64-bit
// Q36.28 value; a square that does not fit saturates and is treated as an
// escape. The configuration registers may only be written while no point is in
// flight.

module mandelbrot_dwell_engine_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [mde_pkg::C_WIDTH-1:0]         point_real,
	input  wire logic [mde_pkg::C_WIDTH-1:0]         point_imag,
	input  wire logic                                cfg_we,
	input  wire logic [mde_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [mde_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
	output logic                                     done,
	output logic [mde_pkg::DWELL_WIDTH-1:0]          dwell,
	output logic                                     inside_res
);

	// Configuration registers, reset to a cap of 65536 iterations and an escape
	// limit of 60000000.
	logic [mde_pkg::MAXIT_WIDTH-1:0] max_iter_q;
	logic [mde_pkg::LIMIT_WIDTH-1:0] esc_limit_q;

	logic              pt_valid;
	logic              pt_take;
	mde_pkg::point_t   pt;
	mde_pkg::mul_req_t mul_req;
	mde_pkg::mul_rsp_t mul_rsp;

	// A write lands on the clock edge at which cfg_we is high; the index picks
	// the register and the data is cut to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= mde_pkg::MAXIT_RESET;
			esc_limit_q <= mde_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (mde_pkg::cfg_reg_t'(cfg_index))
				mde_pkg::CFG_MAX_ITER: begin
					max_iter_q <= cfg_wdata[mde_pkg::MAXIT_WIDTH-1:0];
				end
				mde_pkg::CFG_ESC_LIMIT: begin
					esc_limit_q <= cfg_wdata[mde_pkg::LIMIT_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front end aligns each accepted point and queues it for the core.
	mde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.point_real (point_real),
		.point_imag (point_imag),
		.busy       (busy),
		.pt_valid   (pt_valid),
		.pt_take    (pt_take),
		.pt         (pt)
	);

	// The iteration core sequences one point at a time through the multiplier.
	mde_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_take    (pt_take),
		.pt         (pt),
		.max_iter   (max_iter_q),
		.esc_limit  (esc_limit_q),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.done       (done),
		.dwell      (dwell),
		.inside_res (inside_res)
	);

	// Shared multiplier for all three products of an iteration.
	mde_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule

`default_nettype wire

// ===== bench/mandelbrot_dwell_engine_top_test.sv =====
// Self-checking testbench for the Mandelbrot dwell engine top level.
`timescale 1ns / 1ps

// The bench drives points c into the engine and checks each returned dwell and
// inside flag against an independent model of the escape-time iteration. That
// model is a bit-exact fixed-point calculation held inside the bench.
//
// Structure:
//   - A driver, clocked on the falling edge, takes points from a pending queue.
//     It works in bursts of random length with random gaps between them, and it
//     now and then holds off until every outstanding result has come back.
//   - A monitor, clocked on the rising edge, does two jobs on each edge. It
//     first checks any result strobe against the oldest expectation. It then
//     sees whether a point transfer took place (start high and busy low), and
//     if so it works out the expected result for that point.
//   - The main initial block writes the two registers while the engine is idle.
//     It fills the pending queue one phase at a time and waits for each phase
//     to drain before moving on.
// The result strobe cannot be held off, so there is no receiver back-pressure
// to model. Every iteration runs its three products through the one shared
// multiplier, so the caps are kept small for most of the run. The largest cap
// is only used with points that are certain to escape within a few iterations.

module mandelbrot_dwell_engine_top_test;

	import mde_pkg::*;

	// Generous ceiling on the run. The slowest correct run is about 1850 points
	// at the largest random cap (48), plus the longest sender gaps.
	localparam int RUN_LIMIT   = 6_000_000;
	localparam int SETTLE      = 8;
	localparam int END_DRAIN   = 200;
	localparam int PHASE_ITEMS = 150;
	localparam int MAX_REPORTS = 30;

	localparam logic [Z_WIDTH-1:0] Z_MAX     = {1'b0, {(Z_WIDTH-1){1'b1}}};
	localparam logic [Z_WIDTH-1:0] Z_MIN     = {1'b1, {(Z_WIDTH-1){1'b0}}};
	localparam logic [Z_WIDTH-1:0] Z_NEG_MAX = {1'b1, {(Z_WIDTH-2){1'b0}}, 1'b1};

	// A few handy Q4.28 coordinates.
	localparam logic [C_WIDTH-1:0] Q_ZERO    = 32'h0000_0000;
	localparam logic [C_WIDTH-1:0] Q_TWO     = 32'h2000_0000;
	localparam logic [C_WIDTH-1:0] Q_NEG_TWO = 32'hE000_0000;
	localparam logic [C_WIDTH-1:0] Q_THREE   = 32'h3000_0000;
	localparam logic [C_WIDTH-1:0] Q_QUARTER = 32'h0400_0000;
	localparam logic [C_WIDTH-1:0] Q_NEG_3_4 = 32'hF400_0000;
	localparam logic [C_WIDTH-1:0] Q_TENTH   = 32'h0199_999A;
	localparam logic [C_WIDTH-1:0] Q_0_26    = 32'h0428_F5C3;
	localparam logic [C_WIDTH-1:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [C_WIDTH-1:0] Q_MIN     = 32'h8000_0000;

	typedef struct {
		logic [C_WIDTH-1:0] re;
		logic [C_WIDTH-1:0] im;
	} point_item_t;

	typedef struct {
		logic [DWELL_WIDTH-1:0] dwell;
		logic                   in_set;
		logic [C_WIDTH-1:0]     re;
		logic [C_WIDTH-1:0]     im;
	} dwell_result_t;

	// Regions from which random points are drawn.
	typedef enum int {
		PT_ANY,     // the whole Q4.28 plane
		PT_DISC,    // the square of side four round the origin
		PT_WINDOW,  // the usual picture of the set
		PT_TINY,    // close to the origin, so always inside
		PT_FAR      // real part at least three in size, so always a quick escape
	} pt_kind_t;

	logic                       clk;
	logic                       arst_n     = 1'b0;
	logic                       start      = 1'b0;
	logic [C_WIDTH-1:0]         point_real = '0;
	logic [C_WIDTH-1:0]         point_imag = '0;
	logic                       cfg_we     = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index  = CFG_MAX_ITER;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata  = '0;
	wire logic                  busy;
	wire logic                  done;
	wire logic [DWELL_WIDTH-1:0] dwell;
	wire logic                  inside_res;

	// Register values as the engine should hold them.
	logic [MAXIT_WIDTH-1:0] cap_setting   = MAXIT_RESET;
	logic [LIMIT_WIDTH-1:0] limit_setting = LIMIT_RESET;

	// The model's own iterate and step count. These are left at the values of
	// the last point that was worked out.
	logic [Z_WIDTH-1:0]     orbit_re    = '0;
	logic [Z_WIDTH-1:0]     orbit_im    = '0;
	logic [COUNT_WIDTH-1:0] orbit_steps = '0;

	point_item_t   point_q[$];
	dwell_result_t dwell_expect_q[$];

	// Driver state.
	logic took       = 1'b0;
	int   burst_left = 1;
	int   gap_left   = 0;
	logic drain_hold = 1'b0;

	int mismatch_count = 0;
	int cycle_count    = 0;

	mandelbrot_dwell_engine_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.point_real (point_real),
		.point_imag (point_imag),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.dwell      (dwell),
		.inside_res (inside_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Fixed-point model of the iteration.
	// ---------------------------------------------------------------------

	// Bring a Q4.28 coordinate to the iterate's format.
	function automatic logic [Z_WIDTH-1:0] align_point(input logic [C_WIDTH-1:0] raw);
		logic signed [Z_WIDTH-1:0] v;
		v = Z_WIDTH'($signed(raw));
		if (FRAC_BITS >= C_FRAC)
			return v <<< (FRAC_BITS - C_FRAC);
		return v >>> (C_FRAC - FRAC_BITS);
	endfunction

	function automatic logic [Z_WIDTH-1:0] magnitude(input logic [Z_WIDTH-1:0] v);
		return v[Z_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// Exact product of two magnitudes, shifted right with truncation. The top
	// bit of the return value flags a product that had to be clamped to Z_MAX.
	function automatic logic [Z_WIDTH:0] mag_product(input logic [Z_WIDTH-1:0] a,
	                                                 input logic [Z_WIDTH-1:0] b,
	                                                 input int sh);
		logic [2*Z_WIDTH-1:0] full;
		logic [2*Z_WIDTH-1:0] shifted;
		full    = {{Z_WIDTH{1'b0}}, a} * {{Z_WIDTH{1'b0}}, b};
		shifted = full >> sh;
		if (shifted > {{Z_WIDTH{1'b0}}, Z_MAX})
			return {1'b1, Z_MAX};
		return {1'b0, shifted[Z_WIDTH-1:0]};
	endfunction

	// Signed sum clamped to the symmetric range of plus or minus Z_MAX.
	function automatic logic [Z_WIDTH-1:0] clamp_sum(input logic [Z_WIDTH-1:0] a,
	                                                 input logic [Z_WIDTH-1:0] b);
		logic [Z_WIDTH:0] s;
		s = {a[Z_WIDTH-1], a} + {b[Z_WIDTH-1], b};
		if (!s[Z_WIDTH] && s[Z_WIDTH-1])
			return Z_MAX;
		if (s[Z_WIDTH] && (!s[Z_WIDTH-1] || s[Z_WIDTH-1:0] == Z_MIN))
			return Z_NEG_MAX;
		return s[Z_WIDTH-1:0];
	endfunction

	// Dwell and inside flag for one point under the current register values.
	// The cap register is never wider than the counter, so the cap needs no
	// further clamping here.
	function automatic dwell_result_t predict_dwell(input logic [C_WIDTH-1:0] re_raw,
	                                               input logic [C_WIDTH-1:0] im_raw);
		logic [Z_WIDTH-1:0] cx, cy, nx, xy2, x2, y2;
		logic [Z_WIDTH:0]   pr, sq_sum, limit_wide;
		logic               sq_ovf, escaped, running;
		dwell_result_t      r;
		cx = align_point(re_raw);
		cy = align_point(im_raw);
		limit_wide = '0;
		limit_wide[LIMIT_WIDTH-1:0] = limit_setting;
		x2 = '0;
		y2 = '0;
		sq_ovf = 1'b0;
		escaped = 1'b0;
		running = 1'b1;
		orbit_re = '0;
		orbit_im = '0;
		orbit_steps = '0;
		while (running) begin
			// The escape test comes first, so a point that meets the escape test
			// and the cap at the same check counts as escaped.
			sq_sum = {1'b0, x2} + {1'b0, y2};
			if (sq_ovf || (sq_sum >> FRAC_BITS) >= limit_wide) begin
				escaped = 1'b1;
				running = 1'b0;
			end else if (orbit_steps >= cap_setting) begin
				running = 1'b0;
			end else begin
				nx  = clamp_sum(x2 - y2, cx);
				pr  = mag_product(magnitude(orbit_re), magnitude(orbit_im), FRAC_BITS - 1);
				xy2 = (orbit_re[Z_WIDTH-1] != orbit_im[Z_WIDTH-1]) ?
				      (~pr[Z_WIDTH-1:0] + 1'b1) : pr[Z_WIDTH-1:0];
				orbit_im = clamp_sum(xy2, cy);
				orbit_re = nx;
				// Only a clamped square counts as an escape. A clamped cross
				// product does not.
				pr     = mag_product(magnitude(orbit_re), magnitude(orbit_re), FRAC_BITS);
				x2     = pr[Z_WIDTH-1:0];
				sq_ovf = pr[Z_WIDTH];
				pr     = mag_product(magnitude(orbit_im), magnitude(orbit_im), FRAC_BITS);
				y2     = pr[Z_WIDTH-1:0];
				sq_ovf = sq_ovf | pr[Z_WIDTH];
				orbit_steps = orbit_steps + 1'b1;
			end
		end
		r.dwell  = orbit_steps[DWELL_WIDTH-1:0];
		r.in_set = !escaped;
		r.re     = re_raw;
		r.im     = im_raw;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers.
	// ---------------------------------------------------------------------

	function automatic point_item_t random_point(input pt_kind_t kind);
		point_item_t p;
		case (kind)
			PT_DISC: begin
				p.re = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
				p.im = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
			end
			PT_WINDOW: begin
				p.re = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
				p.im = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
			end
			PT_TINY: begin
				p.re = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
				p.im = $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
			end
			PT_FAR: begin
				p.re = $urandom_range(Q_THREE, Q_MAX);
				if ($urandom_range(0, 1) == 1)
					p.re = -p.re;
				p.im = $urandom;
			end
			default: begin
				p.re = $urandom;
				p.im = $urandom;
			end
		endcase
		return p;
	endfunction

	task automatic queue_point(input logic [C_WIDTH-1:0] re, input logic [C_WIDTH-1:0] im);
		point_item_t p;
		p.re = re;
		p.im = im;
		point_q.push_back(p);
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// One register write, on the falling edge, for a single cycle.
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
	                         input logic [CFG_DATA_WIDTH-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == CFG_MAX_ITER)
			cap_setting = value[MAXIT_WIDTH-1:0];
		else
			limit_setting = value[LIMIT_WIDTH-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes both registers. The unused upper bits of the cap write carry
	// random values, because the engine must ignore them.
	task automatic set_config(input logic [MAXIT_WIDTH-1:0] cap,
	                          input logic [LIMIT_WIDTH-1:0] lim);
		logic [CFG_DATA_WIDTH-1:0] w;
		w = CFG_DATA_WIDTH'($urandom);
		w[MAXIT_WIDTH-1:0] = cap;
		write_reg(CFG_MAX_ITER, w);
		write_reg(CFG_ESC_LIMIT, lim);
		@(posedge clk);
	endtask

	// Waits until nothing is pending, nothing is on the input and no result is
	// outstanding. The check is made on rising edges, when the driver's signals
	// are stable.
	task automatic wait_idle();
		while (point_q.size() != 0 || start || dwell_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Driver: changes the point inputs on the falling edge.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		logic        next_start;
		point_item_t nxt;
		// A point that is still on offer stays put until its transfer happens.
		if (arst_n && !(start && !took)) begin
			next_start = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (drain_hold) begin
				if (dwell_expect_q.size() == 0)
					drain_hold = 1'b0;
			end else if (point_q.size() != 0) begin
				nxt = point_q.pop_front();
				point_real <= nxt.re;
				point_imag <= nxt.im;
				next_start = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// End of a burst. Choose the next gap: mostly short, sometimes
					// none, and sometimes long enough for the engine to run dry.
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 7))
						0, 1:    gap_left = 0;
						7:       gap_left = $urandom_range(41, 400);
						default: gap_left = $urandom_range(1, 40);
					endcase
					drain_hold = ($urandom_range(0, 15) == 0);
				end
			end
			start <= next_start;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: samples on the rising edge. Results are checked before a new
	// transfer is recorded, so a point taken on this edge can never be matched
	// with a result that leaves on the same edge.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		dwell_result_t exp_r;
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (dwell_expect_q.size() == 0) begin
					report_mismatch($sformatf("result (dwell %0d, inside %b) with no point outstanding",
					                          dwell, inside_res));
				end else begin
					exp_r = dwell_expect_q.pop_front();
					if (dwell !== exp_r.dwell)
						report_mismatch($sformatf("dwell %0d, expected %0d for c = (%h, %h)",
						                          dwell, exp_r.dwell, exp_r.re, exp_r.im));
					if (inside_res !== exp_r.in_set)
						report_mismatch($sformatf("inside_res %b, expected %b for c = (%h, %h)",
						                          inside_res, exp_r.in_set, exp_r.re, exp_r.im));
				end
			end
			if (start && !busy)
				dwell_expect_q.push_back(predict_dwell(point_real, point_imag));
			took <= start && !busy;
		end
	end

	// Cycle counter and time-out.
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Test sequence.
	// ---------------------------------------------------------------------
	initial begin
		int                     ph, n;
		logic [MAXIT_WIDTH-1:0] cap;
		logic [LIMIT_WIDTH-1:0] lim;
		pt_kind_t               kind;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register values straight from reset. The cap is large, so only points
		// that escape quickly are used here. These are the four corners of the input
		// range, the most negative value on each axis, and c = 3 on the real axis.
		queue_point(Q_MAX, Q_MAX);
		queue_point(Q_MIN, Q_MIN);
		queue_point(Q_MIN, Q_MAX);
		queue_point(Q_MAX, Q_MIN);
		queue_point(Q_ZERO, Q_MIN);
		queue_point(Q_MIN, Q_ZERO);
		queue_point(Q_THREE, Q_ZERO);
		wait_idle();

		// A cap of zero gives dwell zero with the inside flag set. A limit of
		// zero as well makes the point escape before any step.
		set_config('0, LIMIT_RESET);
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_NEG_3_4, Q_TENTH);
		wait_idle();
		write_reg(CFG_ESC_LIMIT, '0);
		@(posedge clk);
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_MAX, Q_MIN);
		wait_idle();

		// Cap of one with the smallest limit. At c = 2 and c = -2 the escape
		// test and the cap are both met at the same check, and the escape wins.
		set_config(1, 4);
		queue_point(Q_TWO, Q_ZERO);
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_NEG_TWO, Q_ZERO);
		wait_idle();

		// A moderate cap: points inside the set, and slow escapes near its edge.
		set_config(200, 4);
		queue_point(Q_ZERO, Q_ZERO);
		queue_point(Q_NEG_TWO, Q_ZERO);
		queue_point(Q_QUARTER, Q_ZERO);
		queue_point(Q_NEG_3_4, Q_TENTH);
		queue_point(Q_0_26, Q_ZERO);
		wait_idle();

		// The largest cap, used only with points that are certain to escape.
		// First with the reset limit, then with the largest limit that fits.
		set_config('1, LIMIT_RESET);
		queue_point(Q_THREE, Q_ZERO);
		queue_point(-Q_THREE, Q_MAX);
		wait_idle();
		write_reg(CFG_ESC_LIMIT, '1);
		@(posedge clk);
		queue_point(Q_MIN, Q_MIN);
		queue_point(Q_THREE, Q_ZERO);
		wait_idle();

		// Random far points under the largest cap, at both ends of the limit range.
		set_config('1, 4);
		for (n = 0; n < 15; n++)
			point_q.push_back(random_point(PT_FAR));
		wait_idle();
		set_config('1, LIMIT_RESET);
		for (n = 0; n < 15; n++)
			point_q.push_back(random_point(PT_FAR));
		wait_idle();

		// Random phases. Each phase pairs a cap range with a limit setting, and
		// each mixes points inside the set, points near its edge and points
		// drawn from the whole plane.
		for (ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0:       cap = MAXIT_WIDTH'($urandom_range(1, 3));
				1:       cap = MAXIT_WIDTH'($urandom_range(4, 16));
				2:       cap = MAXIT_WIDTH'($urandom_range(17, 48));
				default: cap = MAXIT_WIDTH'($urandom_range(1, 48));
			endcase
			case (ph % 5)
				0:       lim = 4;
				1:       lim = LIMIT_WIDTH'($urandom_range(5, 1000));
				2:       lim = LIMIT_WIDTH'($urandom_range(4, 60000000));
				3:       lim = LIMIT_RESET;
				default: lim = '1;
			endcase
			set_config(cap, lim);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: kind = PT_DISC;
					4, 5, 6:    kind = PT_WINDOW;
					7, 8:       kind = PT_ANY;
					default:    kind = PT_TINY;
				endcase
				point_q.push_back(random_point(kind));
			end
			wait_idle();
		end

		// Leave time for any stray strobe to show up before giving the verdict.
		repeat (END_DRAIN) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== mandelbrot_dwell_engine_top.f =====
src/mde_pkg.sv
src/mde_front.sv
src/mde_mul.sv
src/mde_iter.sv
src/mandelbrot_dwell_engine_top.sv
bench/mandelbrot_dwell_engine_top_test.sv
